/* src/rwt_pkg.sv */
package rwt_pkg;

  localparam int SCREEN_HEIGHT = 512;
  localparam int HALF_SCREEN   = SCREEN_HEIGHT / 2;
  localparam int TILE          = 64;
  localparam int TILE_W        = $clog2(TILE);

  localparam int COL_W   = 12;
  localparam int ROW_W   = 9;
  localparam int DIST_W  = 24;
  localparam int ANG_W   = 12;
  localparam int COORD_W = 16;
  localparam int PD_W    = 12;
  localparam logic [PD_W-1:0] PD_RESET = PD_W'(554);

  localparam int QUARTER  = 2 ** (ANG_W - 2);
  localparam int T_W      = ANG_W - 1;
  localparam int SEG_W    = 5;
  localparam int IDX_W    = T_W - SEG_W;
  localparam int COS_FRAC = 16;
  localparam int COS_W    = COS_FRAC + 1;
  localparam int DIFF_W   = 12;
  localparam int CORR_W   = DIFF_W + SEG_W + 1;

  localparam int PROD_W   = DIST_W + COS_W;
  localparam int LEN_W    = 24;
  localparam int LEN_FRAC = 8;

  localparam int NUM_W      = PD_W + TILE_W + LEN_FRAC;
  localparam int H_W        = NUM_W;
  localparam int HDIV_STEPS = H_W;
  localparam int TN_W       = H_W + 1;
  localparam int TEX_W      = TILE_W;
  localparam int TDIV_STEPS = TEX_W;

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_EAST  = 2'd2,
    FACE_WEST  = 2'd3
  } face_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    face_t             face;
    logic [TEX_W-1:0]  tex_x;
  } pix_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic              in_wall;
    face_t             face;
    logic [TEX_W-1:0]  tex_x;
    logic [TEX_W-1:0]  tex_y;
  } res_t;

  function automatic logic [COS_W-1:0] cos_tab(input logic [IDX_W-1:0] idx);
    logic [COS_W-1:0] v;
    case (idx)
      6'd0:  v = 17'd65536;
      6'd1:  v = 17'd65457;
      6'd2:  v = 17'd65220;
      6'd3:  v = 17'd64827;
      6'd4:  v = 17'd64277;
      6'd5:  v = 17'd63572;
      6'd6:  v = 17'd62714;
      6'd7:  v = 17'd61705;
      6'd8:  v = 17'd60547;
      6'd9:  v = 17'd59244;
      6'd10: v = 17'd57798;
      6'd11: v = 17'd56212;
      6'd12: v = 17'd54491;
      6'd13: v = 17'd52639;
      6'd14: v = 17'd50660;
      6'd15: v = 17'd48559;
      6'd16: v = 17'd46341;
      6'd17: v = 17'd44011;
      6'd18: v = 17'd41576;
      6'd19: v = 17'd39040;
      6'd20: v = 17'd36410;
      6'd21: v = 17'd33692;
      6'd22: v = 17'd30893;
      6'd23: v = 17'd28020;
      6'd24: v = 17'd25079;
      6'd25: v = 17'd22078;
      6'd26: v = 17'd19024;
      6'd27: v = 17'd15924;
      6'd28: v = 17'd12785;
      6'd29: v = 17'd9616;
      6'd30: v = 17'd6424;
      6'd31: v = 17'd3216;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/rwt_if.sv */
interface rwt_in_if import rwt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COL_W-1:0]    column;
  logic [ROW_W-1:0]    row;
  logic [DIST_W-1:0]   hit_distance;
  logic [ANG_W-1:0]    ray_dir;
  logic [ANG_W-1:0]    view_angle;
  logic                hit_vertical;
  logic [COORD_W-1:0]  hit_coord;

  modport source (
    output valid, column, row, hit_distance, ray_dir, view_angle, hit_vertical, hit_coord,
    input  ready
  );
  modport sink (
    input  valid, column, row, hit_distance, ray_dir, view_angle, hit_vertical, hit_coord,
    output ready
  );
endinterface

interface rwt_out_if import rwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  out_column;
  logic [ROW_W-1:0]  out_row;
  logic              in_wall;
  logic [1:0]        face;
  logic [TEX_W-1:0]  tex_x;
  logic [TEX_W-1:0]  tex_y;

  modport source (
    output valid, out_column, out_row, in_wall, face, tex_x, tex_y,
    input  ready
  );
  modport sink (
    input  valid, out_column, out_row, in_wall, face, tex_x, tex_y,
    output ready
  );
endinterface

/* src/rwt_cos.sv */
module rwt_cos import rwt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [COL_W-1:0]    column,
  input  logic [ROW_W-1:0]    row,
  input  logic [DIST_W-1:0]   hit_distance,
  input  logic [ANG_W-1:0]    ray_dir,
  input  logic [ANG_W-1:0]    view_angle,
  input  logic                hit_vertical,
  input  logic [COORD_W-1:0]  hit_coord,
  output logic                out_valid,
  output logic [COS_W-1:0]    mag,
  output logic                neg,
  output logic [DIST_W-1:0]   hit_dist,
  output pix_t                pix
);

  logic [ANG_W-1:0]   diff_ang;
  logic [1:0]         quad;
  logic [T_W-1:0]     offs;
  logic [T_W-1:0]     t;
  logic [IDX_W-1:0]   idx;
  logic [COS_W-1:0]   base_nxt;
  logic [COS_W-1:0]   next_cos;
  logic [DIFF_W-1:0]  diff_nxt;
  pix_t               pix_nxt;
  face_t              face_nxt;

  logic               v1_r;
  logic [COS_W-1:0]   base1_r;
  logic [DIFF_W-1:0]  diff1_r;
  logic [SEG_W-1:0]   frac1_r;
  logic               neg1_r;
  logic [DIST_W-1:0]  dist1_r;
  pix_t               pix1_r;

  logic [CORR_W-1:0]  corr_full;
  logic [COS_W-1:0]   mag_nxt;

  logic               v2_r;
  logic [COS_W-1:0]   mag2_r;
  logic               neg2_r;
  logic [DIST_W-1:0]  dist2_r;
  pix_t               pix2_r;

  // quadrant fold onto the quarter-wave table
  always_comb begin
    diff_ang = ray_dir - view_angle;
    quad     = diff_ang[ANG_W-1:ANG_W-2];
    offs     = {1'b0, diff_ang[ANG_W-3:0]};
    t        = quad[0] ? (T_W'(QUARTER) - offs) : offs;
    idx      = t[T_W-1:SEG_W];
    base_nxt = cos_tab(idx);
    next_cos = cos_tab(idx + IDX_W'(1));
    diff_nxt = DIFF_W'(base_nxt - next_cos);

    if (hit_vertical) begin
      face_nxt = (ray_dir >= ANG_W'(QUARTER) && ray_dir <= ANG_W'(3 * QUARTER))
                 ? FACE_EAST : FACE_WEST;
    end else begin
      face_nxt = (ray_dir <= ANG_W'(2 * QUARTER)) ? FACE_SOUTH : FACE_NORTH;
    end

    pix_nxt.column = column;
    pix_nxt.row    = row;
    pix_nxt.face   = face_nxt;
    pix_nxt.tex_x  = hit_coord[TILE_W-1:0];
  end

  always_comb begin
    corr_full = CORR_W'(diff1_r) * CORR_W'(frac1_r) + CORR_W'(2 ** (SEG_W - 1));
    mag_nxt   = base1_r - COS_W'(corr_full >> SEG_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base1_r <= base_nxt;
      diff1_r <= diff_nxt;
      frac1_r <= t[SEG_W-1:0];
      neg1_r  <= quad[0] ^ quad[1];
      dist1_r <= hit_distance;
      pix1_r  <= pix_nxt;
      mag2_r  <= mag_nxt;
      neg2_r  <= neg1_r;
      dist2_r <= dist1_r;
      pix2_r  <= pix1_r;
    end
  end

  assign out_valid = v2_r;
  assign mag       = mag2_r;
  assign neg       = neg2_r;
  assign hit_dist  = dist2_r;
  assign pix       = pix2_r;

endmodule

/* src/rwt_len.sv */
module rwt_len import rwt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [COS_W-1:0]   mag,
  input  logic               neg,
  input  logic [DIST_W-1:0]  hit_dist,
  input  pix_t               pix_in,
  output logic               out_valid,
  output logic [LEN_W-1:0]   len,
  output pix_t               pix_out
);

  logic [PROD_W-1:0]  prod_nxt;
  logic               v3_r;
  logic [PROD_W-1:0]  prod3_r;
  logic               neg3_r;
  pix_t               pix3_r;

  logic [PROD_W-1:0]  rnd;
  logic [LEN_W-1:0]   raw;
  logic [LEN_W-1:0]   len_nxt;
  logic               v4_r;
  logic [LEN_W-1:0]   len4_r;
  pix_t               pix4_r;

  assign prod_nxt = PROD_W'(hit_dist) * PROD_W'(mag);

  // round back to q16.8, a negative or zero length becomes the smallest one
  always_comb begin
    rnd     = prod3_r + PROD_W'(2 ** (COS_FRAC - 1));
    raw     = rnd[COS_FRAC+LEN_W-1:COS_FRAC];
    len_nxt = (neg3_r || raw == '0) ? LEN_W'(1) : raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_valid;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod3_r <= prod_nxt;
      neg3_r  <= neg;
      pix3_r  <= pix_in;
      len4_r  <= len_nxt;
      pix4_r  <= pix3_r;
    end
  end

  assign out_valid = v4_r;
  assign len       = len4_r;
  assign pix_out   = pix4_r;

endmodule

/* src/rwt_hdiv.sv */
module rwt_hdiv import rwt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [LEN_W-1:0]   len,
  input  logic [PD_W-1:0]    proj_dist,
  input  pix_t               pix_in,
  output logic               out_valid,
  output logic [H_W-1:0]     h,
  output pix_t               pix_out
);

  logic [LEN_W-1:0]  rem_in   [HDIV_STEPS];
  logic [NUM_W-1:0]  dvd_in   [HDIV_STEPS];
  logic [H_W-1:0]    quo_in   [HDIV_STEPS];
  logic [LEN_W-1:0]  len_in   [HDIV_STEPS];
  logic              v_in     [HDIV_STEPS];
  pix_t              pix_sin  [HDIV_STEPS];

  logic [LEN_W:0]    trial    [HDIV_STEPS];
  logic              ge       [HDIV_STEPS];
  logic [LEN_W-1:0]  rem_nxt  [HDIV_STEPS];

  logic [LEN_W-1:0]  rem_r    [HDIV_STEPS];
  logic [NUM_W-1:0]  dvd_r    [HDIV_STEPS];
  logic [H_W-1:0]    quo_r    [HDIV_STEPS];
  logic [LEN_W-1:0]  len_r    [HDIV_STEPS];
  logic              v_r      [HDIV_STEPS];
  pix_t              pix_r    [HDIV_STEPS];

  // one quotient bit per stage, restoring
  always_comb begin
    rem_in[0]  = '0;
    dvd_in[0]  = {proj_dist, (TILE_W + LEN_FRAC)'(0)};
    quo_in[0]  = '0;
    len_in[0]  = len;
    v_in[0]    = in_valid;
    pix_sin[0] = pix_in;
    for (int k = 1; k < HDIV_STEPS; k++) begin
      rem_in[k]  = rem_r[k-1];
      dvd_in[k]  = dvd_r[k-1];
      quo_in[k]  = quo_r[k-1];
      len_in[k]  = len_r[k-1];
      v_in[k]    = v_r[k-1];
      pix_sin[k] = pix_r[k-1];
    end
    for (int k = 0; k < HDIV_STEPS; k++) begin
      trial[k]   = {rem_in[k], dvd_in[k][NUM_W-1]};
      ge[k]      = trial[k] >= {1'b0, len_in[k]};
      rem_nxt[k] = ge[k] ? LEN_W'(trial[k] - {1'b0, len_in[k]}) : trial[k][LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HDIV_STEPS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < HDIV_STEPS; k++) v_r[k] <= v_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < HDIV_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        dvd_r[k] <= {dvd_in[k][NUM_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[k][H_W-2:0], ge[k]};
        len_r[k] <= len_in[k];
        pix_r[k] <= pix_sin[k];
      end
    end
  end

  assign out_valid = v_r[HDIV_STEPS-1];
  assign h         = quo_r[HDIV_STEPS-1];
  assign pix_out   = pix_r[HDIV_STEPS-1];

endmodule

/* src/rwt_texel.sv */
module rwt_texel import rwt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [H_W-1:0]  h,
  input  pix_t            pix_in,
  output logic            out_valid,
  output res_t            res
);

  logic [H_W-1:0]   half;
  logic [H_W-1:0]   row_ext;
  logic [H_W-1:0]   lo_sum;
  logic [H_W-1:0]   hi_sum;
  logic             in_wall_nxt;
  logic [TN_W-1:0]  num_nxt;

  logic             sp_v_r;
  logic [H_W-1:0]   sp_h_r;
  logic [TN_W-1:0]  sp_num_r;
  logic             sp_in_wall_r;
  pix_t             sp_pix_r;

  logic [TN_W-1:0]   rem_in   [TDIV_STEPS];
  logic [H_W-1:0]    h_in     [TDIV_STEPS];
  logic [TEX_W-1:0]  quo_in   [TDIV_STEPS];
  logic              wall_in  [TDIV_STEPS];
  logic              v_in     [TDIV_STEPS];
  pix_t              pix_sin  [TDIV_STEPS];
  logic              ge       [TDIV_STEPS];
  logic [TN_W-1:0]   sub      [TDIV_STEPS];

  logic [TN_W-1:0]   rem_r    [TDIV_STEPS];
  logic [H_W-1:0]    h_r      [TDIV_STEPS];
  logic [TEX_W-1:0]  quo_r    [TDIV_STEPS];
  logic              wall_r   [TDIV_STEPS];
  logic              v_r      [TDIV_STEPS];
  pix_t              pix_r    [TDIV_STEPS];

  // strip span test, clamped to the screen
  always_comb begin
    half        = {1'b0, h[H_W-1:1]};
    row_ext     = H_W'(pix_in.row);
    lo_sum      = row_ext + half;
    hi_sum      = H_W'(HALF_SCREEN) + half;
    in_wall_nxt = (lo_sum >= H_W'(HALF_SCREEN)) && (row_ext < hi_sum) &&
                  (row_ext < H_W'(SCREEN_HEIGHT));
    num_nxt     = in_wall_nxt ? ({lo_sum, 1'b0} - TN_W'(SCREEN_HEIGHT)) : '0;
  end

  // texel row: num * TILE / (2 h), num below 2 h inside the strip
  always_comb begin
    rem_in[0]  = sp_num_r;
    h_in[0]    = sp_h_r;
    quo_in[0]  = '0;
    wall_in[0] = sp_in_wall_r;
    v_in[0]    = sp_v_r;
    pix_sin[0] = sp_pix_r;
    for (int k = 1; k < TDIV_STEPS; k++) begin
      rem_in[k]  = rem_r[k-1];
      h_in[k]    = h_r[k-1];
      quo_in[k]  = quo_r[k-1];
      wall_in[k] = wall_r[k-1];
      v_in[k]    = v_r[k-1];
      pix_sin[k] = pix_r[k-1];
    end
    for (int k = 0; k < TDIV_STEPS; k++) begin
      ge[k]  = wall_in[k] && (rem_in[k] >= TN_W'(h_in[k]));
      sub[k] = ge[k] ? (rem_in[k] - TN_W'(h_in[k])) : rem_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_v_r <= 1'b0;
      for (int k = 0; k < TDIV_STEPS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      sp_v_r <= in_valid;
      for (int k = 0; k < TDIV_STEPS; k++) v_r[k] <= v_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_h_r       <= h;
      sp_num_r     <= num_nxt;
      sp_in_wall_r <= in_wall_nxt;
      sp_pix_r     <= pix_in;
      for (int k = 0; k < TDIV_STEPS; k++) begin
        rem_r[k]  <= {sub[k][TN_W-2:0], 1'b0};
        h_r[k]    <= h_in[k];
        quo_r[k]  <= {quo_in[k][TEX_W-2:0], ge[k]};
        wall_r[k] <= wall_in[k];
        pix_r[k]  <= pix_sin[k];
      end
    end
  end

  always_comb begin
    res.column  = pix_r[TDIV_STEPS-1].column;
    res.row     = pix_r[TDIV_STEPS-1].row;
    res.in_wall = wall_r[TDIV_STEPS-1];
    res.face    = pix_r[TDIV_STEPS-1].face;
    res.tex_x   = pix_r[TDIV_STEPS-1].tex_x;
    res.tex_y   = quo_r[TDIV_STEPS-1];
  end

  assign out_valid = v_r[TDIV_STEPS-1];

endmodule

/* src/rwt_skid.sv */
module rwt_skid import rwt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  res_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_data
);

  logic  main_v_r;
  logic  spare_v_r;
  res_t  main_r;
  res_t  spare_r;
  logic  load;

  assign load     = out_ready || !main_v_r;
  assign in_ready = !spare_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (load) begin
      main_v_r  <= spare_v_r || in_valid;
      spare_v_r <= 1'b0;
    end else if (in_valid && !spare_v_r) begin
      spare_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      main_r <= spare_v_r ? spare_r : in_data;
    end else if (in_valid && !spare_v_r) begin
      spare_r <= in_data;
    end
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

/* src/raycast_wall_texel_mapper.sv */
// raycast wall texel mapper
// in_ch carries one pixel request per transaction (column, row, q16.8 hit
// distance, ray and view angles, hit orientation and hit coordinate);
// out_ch returns one result per request, in order: the pixel position, the
// in-wall flag, the wall face and the texel coordinates.
// cfg_we/cfg_wdata write the projection distance; write it only while no
// transaction is in flight.
// throughput: one transaction per clock cycle while out_ch does not stall.
// an input transaction passes through the cosine and multiply stages, the
// 26-stage height divider (one quotient bit per stage), the span stage, the
// 6-stage texel row divider and the output stage before its result is valid.
// reset clears all valid bits and loads the projection distance with 554.
// when out_ch stalls, the output stage and a one-entry skid buffer hold
// results; once the skid buffer fills, in_ch.ready drops and the whole
// pipeline freezes, nothing is lost or repeated.
module raycast_wall_texel_mapper import rwt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rwt_in_if.sink             in_ch,
  rwt_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [PD_W-1:0]    cfg_wdata
);

  logic               en;
  logic [PD_W-1:0]    proj_dist_r;

  logic               cos_v;
  logic [COS_W-1:0]   cos_mag;
  logic               cos_neg;
  logic [DIST_W-1:0]  cos_dist;
  pix_t               cos_pix;

  logic               len_v;
  logic [LEN_W-1:0]   len_val;
  pix_t               len_pix;

  logic               hd_v;
  logic [H_W-1:0]     hd_h;
  pix_t               hd_pix;

  logic               tx_v;
  res_t               tx_res;
  res_t               out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proj_dist_r <= PD_RESET;
    end else if (cfg_we) begin
      proj_dist_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = en;

  rwt_cos u_cos (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_ch.valid),
    .column       (in_ch.column),
    .row          (in_ch.row),
    .hit_distance (in_ch.hit_distance),
    .ray_dir      (in_ch.ray_dir),
    .view_angle   (in_ch.view_angle),
    .hit_vertical (in_ch.hit_vertical),
    .hit_coord    (in_ch.hit_coord),
    .out_valid    (cos_v),
    .mag          (cos_mag),
    .neg          (cos_neg),
    .hit_dist     (cos_dist),
    .pix          (cos_pix)
  );

  rwt_len u_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cos_v),
    .mag       (cos_mag),
    .neg       (cos_neg),
    .hit_dist  (cos_dist),
    .pix_in    (cos_pix),
    .out_valid (len_v),
    .len       (len_val),
    .pix_out   (len_pix)
  );

  rwt_hdiv u_hdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (len_v),
    .len       (len_val),
    .proj_dist (proj_dist_r),
    .pix_in    (len_pix),
    .out_valid (hd_v),
    .h         (hd_h),
    .pix_out   (hd_pix)
  );

  rwt_texel u_texel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (hd_v),
    .h         (hd_h),
    .pix_in    (hd_pix),
    .out_valid (tx_v),
    .res       (tx_res)
  );

  rwt_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tx_v),
    .in_ready  (en),
    .in_data   (tx_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.out_column = out_res.column;
  assign out_ch.out_row    = out_res.row;
  assign out_ch.in_wall    = out_res.in_wall;
  assign out_ch.face       = out_res.face;
  assign out_ch.tex_x      = out_res.tex_x;
  assign out_ch.tex_y      = out_res.tex_y;

  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("pipeline frozen with no result at the output");

  a_texel_row_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.in_wall |-> out_ch.tex_y == '0)
    else $error("nonzero texel row outside the wall strip");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready && !out_ch.ready |=> !in_ch.ready)
    else $error("pipeline resumed while the output stays stalled");

endmodule
